>>> hw/rtl/sttab_pkg.sv
// ----------------------------------------------------------------------------
// sttab_pkg
// Shared widths, codes and types of the timer slot table.
// ----------------------------------------------------------------------------
package sttab_pkg;

	// sizing
	localparam int DEF_SLOT_COUNT = 8;
	localparam int MAX_FIRES      = 8;
	localparam int FIRE_CNT_W     = $clog2(MAX_FIRES + 1);

	// field widths
	localparam int CMD_W    = 2;
	localparam int LABEL_W  = 8;
	localparam int PERIOD_W = 16;
	localparam int TIME_W   = 32;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 3;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_CREATE  = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_QUERY   = 2'd3
	} command_t;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_FIRE   = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_ANSWER = 2'd2
	} kind_t;

	// one slot as held in the slot memory
	typedef struct packed {
		logic [LABEL_W-1:0]  label;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   ref_time;
		logic                ms_base;
		logic                one_shot;
	} slot_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic eval;
		logic calc;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stall;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hw/rtl/sttab_if.sv
// ----------------------------------------------------------------------------
// sttab_if
// Request and response channels of the timer slot table.
// ----------------------------------------------------------------------------

// request channel: one command word
interface sttab_req_if;
	logic                             valid;
	logic                             ready;
	logic [sttab_pkg::CMD_W-1:0]      command;
	logic [sttab_pkg::LABEL_W-1:0]    label_id;
	logic [sttab_pkg::PERIOD_W-1:0]   interval;
	logic                             use_ms;
	logic [sttab_pkg::TIME_W-1:0]     time_ms;
	logic [sttab_pkg::TIME_W-1:0]     time_s;

	modport source (output valid, command, label_id, interval, use_ms, time_ms, time_s,
		input ready);
	modport sink (input valid, command, label_id, interval, use_ms, time_ms, time_s,
		output ready);
endinterface

// response channel: one result word
interface sttab_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [sttab_pkg::KIND_W-1:0]     kind;
	logic                             ok;
	logic [sttab_pkg::SLOT_W-1:0]     slot;
	logic [sttab_pkg::PERIOD_W-1:0]   time_left;
	logic                             last;

	modport source (output valid, kind, ok, slot, time_left, last, input ready);
	modport sink (input valid, kind, ok, slot, time_left, last, output ready);
endinterface

>>> hw/rtl/sttab_ctrl.sv
// ----------------------------------------------------------------------------
// sttab_ctrl
// Sequencer of the timer slot table: takes a command word, walks the slots
// one per cycle unless the datapath stalls, then closes it with its result.
// ----------------------------------------------------------------------------
module sttab_ctrl #(
	parameter int SLOT_COUNT = sttab_pkg::DEF_SLOT_COUNT,
	parameter int IDX_W      = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  sttab_pkg::dp_stat_t  stat,
	output sttab_pkg::dp_cmd_t   cmd,
	output logic [IDX_W-1:0]     idx,
	output logic [IDX_W-1:0]     rd_addr
);
	import sttab_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_FIN
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign idx       = idx_q;

	// commands to the datapath
	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					cmd.rd_en = 1'b1;
				end
			end
			ST_SCAN: begin
				if (!stat.stall) begin
					cmd.eval = 1'b1;
					if (idx_q != LAST_IDX) begin
						cmd.rd_en = 1'b1;
						rd_addr   = idx_q + IDX_W'(1);
					end
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (!stat.stall) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_CALC;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_CALC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/sttab_dp.sv
// ----------------------------------------------------------------------------
// sttab_dp
// Datapath of the timer slot table: slot memory, used bits, scan results
// and the result word register.
// ----------------------------------------------------------------------------
module sttab_dp #(
	parameter int SLOT_COUNT = sttab_pkg::DEF_SLOT_COUNT,
	parameter int IDX_W      = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sttab_pkg::dp_cmd_t              cmd,
	input  logic [IDX_W-1:0]                idx,
	input  logic [IDX_W-1:0]                rd_addr,
	output sttab_pkg::dp_stat_t             stat,
	input  logic [sttab_pkg::CMD_W-1:0]     command,
	input  logic [sttab_pkg::LABEL_W-1:0]   label_id,
	input  logic [sttab_pkg::PERIOD_W-1:0]  interval,
	input  logic                            use_ms,
	input  logic [sttab_pkg::TIME_W-1:0]    time_ms,
	input  logic [sttab_pkg::TIME_W-1:0]    time_s,
	sttab_rsp_if.source                     rsp
);
	import sttab_pkg::*;

	// latched command word
	command_t              cmd_q;
	logic [LABEL_W-1:0]    label_q;
	logic [PERIOD_W-1:0]   interval_q;
	logic                  use_ms_q;
	logic [TIME_W-1:0]     time_ms_q;
	logic [TIME_W-1:0]     time_s_q;

	// slot store
	logic [SLOT_COUNT-1:0] used_q;
	slot_entry_t           slot_mem [SLOT_COUNT];
	slot_entry_t           rd_q;

	// scan results
	logic                  match_found_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic [PERIOD_W-1:0]   match_period_q;
	logic [TIME_W-1:0]     match_ref_q;
	logic                  match_ms_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic [TIME_W-1:0]     elapsed_q;

	// result word register
	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic                  out_ok_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [PERIOD_W-1:0]   out_left_q;
	logic                  out_last_q;

	// per-slot evaluation
	logic [TIME_W-1:0]     now_slot;
	logic [TIME_W-1:0]     slot_elapsed;
	logic                  slot_used;
	logic                  slot_due;
	logic                  label_hit;
	logic                  record;
	logic                  out_free;
	logic [TIME_W-1:0]     now_new;
	logic [TIME_W-1:0]     period_ext;
	logic [PERIOD_W-1:0]   left_calc;

	// word assembly and store updates
	logic                  emit;
	kind_t                 e_kind;
	logic                  e_ok;
	logic [SLOT_W-1:0]     e_slot;
	logic [PERIOD_W-1:0]   e_left;
	logic                  e_last;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	slot_entry_t           wr_entry;
	logic                  used_set;
	logic                  used_clr;

	assign now_slot     = rd_q.ms_base ? time_ms_q : time_s_q;
	assign slot_elapsed = now_slot - rd_q.ref_time;
	assign slot_used    = used_q[idx];
	assign slot_due     = slot_used && (slot_elapsed >= TIME_W'(rd_q.period));
	assign label_hit    = slot_used && !rd_q.one_shot && (rd_q.label == label_q);
	assign out_free     = !out_valid_q || rsp.ready;
	assign record       = (cmd_q == CMD_TICK) && slot_due
		&& (fire_cnt_q < FIRE_CNT_W'(MAX_FIRES));
	assign now_new      = use_ms_q ? time_ms_q : time_s_q;

	// time left, saturating at zero
	assign period_ext = TIME_W'(match_period_q);
	assign left_calc  = (elapsed_q < period_ext) ? PERIOD_W'(period_ext - elapsed_q) : '0;

	assign stat.stall    = record && pend_valid_q && !out_free;
	assign stat.out_free = out_free;

	// result word and store write selection
	always_comb begin
		emit     = 1'b0;
		e_kind   = KIND_FIRE;
		e_ok     = 1'b0;
		e_slot   = '0;
		e_left   = '0;
		e_last   = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = idx;
		wr_entry = rd_q;
		used_set = 1'b0;
		used_clr = 1'b0;
		if (cmd.eval && (cmd_q == CMD_TICK) && slot_due) begin
			wr_en             = 1'b1;
			wr_entry.ref_time = now_slot;
			used_clr          = rd_q.one_shot;
			if (record && pend_valid_q) begin
				emit   = 1'b1;
				e_kind = KIND_FIRE;
				e_ok   = 1'b1;
				e_slot = SLOT_W'(pend_idx_q);
			end
		end
		if (cmd.finish) begin
			case (cmd_q)
				CMD_TICK: begin
					if (pend_valid_q) begin
						emit   = 1'b1;
						e_kind = KIND_FIRE;
						e_ok   = 1'b1;
						e_slot = SLOT_W'(pend_idx_q);
						e_last = 1'b1;
					end
				end
				CMD_CREATE: begin
					emit   = 1'b1;
					e_kind = KIND_ACK;
					e_last = 1'b1;
					if (!match_found_q && free_found_q) begin
						e_ok     = 1'b1;
						e_slot   = SLOT_W'(free_idx_q);
						wr_en    = 1'b1;
						wr_idx   = free_idx_q;
						used_set = 1'b1;
						wr_entry = '{label: label_q, period: interval_q, ref_time: '0,
							ms_base: use_ms_q, one_shot: 1'b0};
					end
				end
				CMD_TIMEOUT: begin
					emit   = 1'b1;
					e_kind = KIND_ACK;
					e_last = 1'b1;
					if (free_found_q) begin
						e_ok     = 1'b1;
						e_slot   = SLOT_W'(free_idx_q);
						wr_en    = 1'b1;
						wr_idx   = free_idx_q;
						used_set = 1'b1;
						wr_entry = '{label: '0, period: interval_q, ref_time: now_new,
							ms_base: use_ms_q, one_shot: 1'b1};
					end
				end
				CMD_QUERY: begin
					emit   = 1'b1;
					e_kind = KIND_ANSWER;
					e_last = 1'b1;
					if (match_found_q) begin
						e_ok   = 1'b1;
						e_slot = SLOT_W'(match_idx_q);
						e_left = left_calc;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_idx] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			fire_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (used_set) begin
				used_q[wr_idx] <= 1'b1;
			end
			if (used_clr) begin
				used_q[idx] <= 1'b0;
			end
			if (cmd.load) begin
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				pend_valid_q  <= 1'b0;
				fire_cnt_q    <= '0;
			end
			if (cmd.eval) begin
				if (label_hit) begin
					match_found_q <= 1'b1;
				end
				if (!slot_used) begin
					free_found_q <= 1'b1;
				end
				if (record) begin
					pend_valid_q <= 1'b1;
					fire_cnt_q   <= fire_cnt_q + FIRE_CNT_W'(1);
				end
			end
			if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= command_t'(command);
			label_q    <= label_id;
			interval_q <= interval;
			use_ms_q   <= use_ms;
			time_ms_q  <= time_ms;
			time_s_q   <= time_s;
		end
		if (cmd.eval) begin
			if (label_hit && !match_found_q) begin
				match_idx_q    <= idx;
				match_period_q <= rd_q.period;
				match_ref_q    <= rd_q.ref_time;
				match_ms_q     <= rd_q.ms_base;
			end
			if (!slot_used && !free_found_q) begin
				free_idx_q <= idx;
			end
			if (record) begin
				pend_idx_q <= idx;
			end
		end
		if (cmd.calc) begin
			elapsed_q <= (match_ms_q ? time_ms_q : time_s_q) - match_ref_q;
		end
		if (emit) begin
			out_kind_q <= e_kind;
			out_ok_q   <= e_ok;
			out_slot_q <= e_slot;
			out_left_q <= e_left;
			out_last_q <= e_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.kind      = out_kind_q;
	assign rsp.ok        = out_ok_q;
	assign rsp.slot      = out_slot_q;
	assign rsp.time_left = out_left_q;
	assign rsp.last      = out_last_q;

`ifndef NO_ASSERTIONS
	// a word is only loaded when the register is free or being taken
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result word overwritten before it was taken");

	// no more fires reported than the word limit allows
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_CNT_W'(MAX_FIRES))
		else $error("fire count beyond limit");

	// a claimed slot was free at the time of the claim
	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		used_set |-> !used_q[wr_idx])
		else $error("claimed slot already in use");

	// the held fire is flushed by the end of a command
	a_pend_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !pend_valid_q)
		else $error("held fire left over after command end");
`endif

endmodule

>>> hw/rtl/software_timer_slot_table_core.sv
// ----------------------------------------------------------------------------
// software_timer_slot_table_core
// Table of periodic and one-shot timer slots driven by tick, create,
// set-timeout and query command words.
// ----------------------------------------------------------------------------
// Each accepted command word walks the whole slot table, one slot per cycle
// unless a fire word waits on a full result register, through the single read
// port of the slot memory; the time-left subtraction is then registered in
// ST_CALC and the command is closed in ST_FIN once the result register is free.
// A tick gives one fire word per due slot (at most eight, ascending slot order,
// the final one marked last) and may give none; every other command gives
// exactly one word. The result register lets the last word of a command wait
// while the next command is taken. No clearing pass follows reset: the used
// bits are flip-flops and the contents of a slot entry count only while its
// used bit is set.
// ----------------------------------------------------------------------------
module software_timer_slot_table_core #(
	parameter int SLOT_COUNT = sttab_pkg::DEF_SLOT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	sttab_req_if.sink   req,
	sttab_rsp_if.source rsp
);
	import sttab_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] rd_addr;
	logic             req_ready;

	assign req.ready = req_ready;

	// sequencer
	sttab_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd),
		.idx       (idx),
		.rd_addr   (rd_addr)
	);

	// slot store and result word
	sttab_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx      (idx),
		.rd_addr  (rd_addr),
		.stat     (stat),
		.command  (req.command),
		.label_id (req.label_id),
		.interval (req.interval),
		.use_ms   (req.use_ms),
		.time_ms  (req.time_ms),
		.time_s   (req.time_s),
		.rsp      (rsp)
	);

endmodule
